/* hw/rtl/idg_pkg.sv */
// ----------------------------------------------------------------------------
// idg_pkg
// Shared types, reset constants and table lookups for the DVFS governor.
// ----------------------------------------------------------------------------
package idg_pkg;

  localparam int LVL_W   = 3;
  localparam int FREQ_W  = 16;
  localparam int LOAD_W  = 7;
  localparam int QUOT_W  = FREQ_W + LOAD_W;
  localparam int TL_W    = 8;
  localparam int CFG_W   = 64;
  localparam int CIDX_W  = 4;

  localparam logic [CIDX_W-1:0] REG_OPP_LOW   = 4'd0;
  localparam logic [CIDX_W-1:0] REG_OPP_HIGH  = 4'd1;
  localparam logic [CIDX_W-1:0] REG_TLOADS    = 4'd2;
  localparam logic [CIDX_W-1:0] REG_DELAYS    = 4'd3;
  localparam logic [CIDX_W-1:0] REG_HS_FREQ   = 4'd4;
  localparam logic [CIDX_W-1:0] REG_HS_LOAD   = 4'd5;
  localparam logic [CIDX_W-1:0] REG_MIN_SMP   = 4'd6;
  localparam logic [CIDX_W-1:0] REG_MAX_HYST  = 4'd7;

  localparam logic [CFG_W-1:0]  RST_OPP_LOW   = 64'd337773837562675500;
  localparam logic [CFG_W-1:0]  RST_OPP_HIGH  = 64'd675548963654862300;
  localparam logic [CFG_W-1:0]  RST_TLOADS    = 64'd6510615555426900570;
  localparam logic [CFG_W-1:0]  RST_DELAYS    = 64'd72340172838076673;
  localparam logic [FREQ_W-1:0] RST_HS_FREQ   = 16'd1200;
  localparam logic [LOAD_W-1:0] RST_HS_LOAD   = 7'd90;
  localparam logic [FREQ_W-1:0] RST_MIN_SMP   = 16'd1;
  localparam logic [FREQ_W-1:0] RST_MAX_HYST  = 16'd2;

  typedef logic [7:0][FREQ_W-1:0] opp_tab_t;
  typedef logic [7:0][TL_W-1:0]   byte_tab_t;

  typedef enum logic [3:0] {
    S_IDLE, S_START, S_DIVSET, S_DIV, S_EVAL, S_FIX, S_DEC1, S_DEC2
  } state_t;

  typedef struct packed {
    logic start;
    logic div_init;
    logic div_step;
    logic eval;
    logic fix;
    logic dec1;
    logic dec2;
  } cmd_t;

  typedef struct packed {
    logic div_last;
    logic eval_fix;
    logic eval_stop;
    logic fix_stop;
    logic rounds_last;
    logic hold1;
  } stat_t;

  function automatic logic [LVL_W-1:0] level_of(opp_tab_t t, int n, logic [QUOT_W-1:0] x);
    logic [LVL_W-1:0] lvl;
    lvl = '0;
    for (int i = 0; i < 8; i++) begin
      if (i < n && {{LOAD_W{1'b0}}, t[i]} <= x) lvl = LVL_W'(i);
    end
    return lvl;
  endfunction

  function automatic logic [FREQ_W-1:0] floor_opp(opp_tab_t t, int n, logic [QUOT_W-1:0] x);
    return t[level_of(t, n, x)];
  endfunction

  function automatic logic [FREQ_W-1:0] ceil_opp(opp_tab_t t, int n, logic [QUOT_W-1:0] x);
    logic [FREQ_W-1:0] f;
    logic              hit;
    f   = t[n-1];
    hit = 1'b0;
    for (int i = 0; i < 8; i++) begin
      if (i < n && !hit && {{LOAD_W{1'b0}}, t[i]} >= x) begin
        f   = t[i];
        hit = 1'b1;
      end
    end
    return f;
  endfunction

endpackage

/* hw/rtl/idg_ctrl.sv */
// ----------------------------------------------------------------------------
// idg_ctrl
// Sequencer for search rounds, divider steps and the final decision.
// ----------------------------------------------------------------------------
module idg_ctrl
  import idg_pkg::*;
(
  input  logic  clk,
  input  logic  rst_n,
  input  logic  in_valid,
  output logic  in_ready,
  output logic  out_valid,
  input  logic  out_ready,
  input  stat_t stat,
  output cmd_t  cmd
);

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_comb begin
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r && !out_ready;
    cmd           = '0;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.start = 1'b1;
          state_nxt = S_START;
        end
      end
      S_START: state_nxt = S_DIVSET;
      S_DIVSET: begin
        cmd.div_init = 1'b1;
        state_nxt    = S_DIV;
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        if (stat.div_last) state_nxt = S_EVAL;
      end
      S_EVAL: begin
        cmd.eval = 1'b1;
        if (stat.eval_fix) state_nxt = S_FIX;
        else if (stat.eval_stop || stat.rounds_last) state_nxt = S_DEC1;
        else state_nxt = S_DIVSET;
      end
      S_FIX: begin
        cmd.fix = 1'b1;
        if (stat.fix_stop || stat.rounds_last) state_nxt = S_DEC1;
        else state_nxt = S_DIVSET;
      end
      S_DEC1: begin
        // hold until the previous word has left
        if (!out_valid_r) begin
          cmd.dec1 = 1'b1;
          if (stat.hold1) begin
            out_valid_nxt = 1'b1;
            state_nxt     = S_IDLE;
          end else begin
            state_nxt = S_DEC2;
          end
        end
      end
      S_DEC2: begin
        cmd.dec2      = 1'b1;
        out_valid_nxt = 1'b1;
        state_nxt     = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;

  a_start: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> state_r == S_START)
    else $error("accepted word did not start a search");
  a_div_end: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_DIV && stat.div_last |=> state_r == S_EVAL)
    else $error("divider end not followed by evaluation");
  a_no_clobber: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.dec1 |-> !out_valid_r)
    else $error("decision taken while result pending");
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_ready |=> out_valid_r)
    else $error("result dropped before accept");

endmodule

/* hw/rtl/idg_datapath.sv */
// ----------------------------------------------------------------------------
// idg_datapath
// Configuration, governor state, bracketing search and restoring divider.
// ----------------------------------------------------------------------------
module idg_datapath
  import idg_pkg::*;
#(
  parameter int NUM_LEVELS = 8,
  parameter int TIME_BITS  = 32
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cfg_we,
  input  logic [CIDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]  cfg_data,
  input  logic [LOAD_W-1:0] in_cpu_load,
  input  logic [31:0]       in_tick_now,
  output logic [FREQ_W-1:0] out_chosen_frequency,
  input  cmd_t              cmd,
  output stat_t             stat
);

  localparam int ROUNDS = 2 * NUM_LEVELS + 2;
  localparam int RND_W  = $clog2(ROUNDS + 1);
  localparam int DCNT_W = $clog2(QUOT_W);
  localparam int TW     = TIME_BITS;

  logic [CFG_W-1:0]  opp_lo_r, opp_hi_r, tloads_r, delays_r;
  logic [FREQ_W-1:0] hs_freq_r, min_smp_r, max_hyst_r;
  logic [LOAD_W-1:0] hs_load_r;

  logic [FREQ_W-1:0] cur_r, floor_f_r;
  logic [TW-1:0]     floor_st_r, hs_st_r, mh_st_r;

  logic [LOAD_W-1:0] load_r;
  logic [TW-1:0]     now_r;
  logic [QUOT_W-1:0] adj_r, q_r;
  logic [TL_W-1:0]   rem_r, divisor_r;
  logic [DCNT_W-1:0] dcnt_r;
  logic [RND_W-1:0]  rnd_r;
  logic [FREQ_W-1:0] freq_r, prev_r, fmin_r, nf2_r, res_r;
  logic [FREQ_W:0]   fmax_r;
  logic              fix_up_r, jmax_r;

  opp_tab_t  tab;
  byte_tab_t tl_tab, dl_tab;
  assign tab    = opp_tab_t'({opp_hi_r, opp_lo_r});
  assign tl_tab = byte_tab_t'(tloads_r);
  assign dl_tab = byte_tab_t'(delays_r);

  logic [FREQ_W-1:0] maxf;
  assign maxf = tab[NUM_LEVELS-1];

  // divider step
  logic [TL_W:0]   dtrial;
  logic            dge;
  assign dtrial = {rem_r, q_r[QUOT_W-1]};
  assign dge    = dtrial >= {1'b0, divisor_r};

  logic [TL_W-1:0] tl_sel;
  assign tl_sel = tl_tab[level_of(tab, NUM_LEVELS, {{LOAD_W{1'b0}}, freq_r})];

  // search evaluation
  logic [FREQ_W-1:0] ev_f;
  logic              ev_up, ev_dn, ev_fix;
  assign ev_f   = floor_opp(tab, NUM_LEVELS, q_r);
  assign ev_up  = ev_f > freq_r;
  assign ev_dn  = ev_f < freq_r;
  assign ev_fix = (ev_up && {1'b0, ev_f} >= fmax_r) || (ev_dn && ev_f <= fmin_r);

  logic [FREQ_W-1:0] fx_c, fx_f;
  logic              fx_brk;
  logic [FREQ_W:0]   fmax_m1, fmin_p1;
  assign fmax_m1 = fmax_r - 1'b1;
  assign fmin_p1 = {1'b0, fmin_r} + 1'b1;
  always_comb begin
    if (fix_up_r) begin
      fx_c   = ceil_opp(tab, NUM_LEVELS, QUOT_W'(fmax_m1));
      fx_brk = fx_c == fmin_r;
      fx_f   = fx_brk ? fmax_r[FREQ_W-1:0] : fx_c;
    end else begin
      fx_c   = floor_opp(tab, NUM_LEVELS, QUOT_W'(fmin_p1));
      fx_brk = {1'b0, fx_c} == fmax_r;
      fx_f   = fx_c;
    end
  end

  // decision
  logic [TW-1:0]     el_mh, el_hs, el_fl;
  logic              hyst, geh, jmax, hold1, hold2;
  logic [FREQ_W-1:0] nf1;
  logic [TL_W-1:0]   dly;
  assign el_mh = now_r - mh_st_r;
  assign el_hs = now_r - hs_st_r;
  assign el_fl = now_r - floor_st_r;
  assign hyst  = el_mh < TW'(max_hyst_r);
  assign geh   = load_r >= hs_load_r;
  assign jmax  = hyst && geh;
  assign dly   = dl_tab[level_of(tab, NUM_LEVELS, {{LOAD_W{1'b0}}, cur_r})];
  always_comb begin
    if (jmax) nf1 = maxf;
    else if (geh && (cur_r < hs_freq_r || freq_r < hs_freq_r)) nf1 = hs_freq_r;
    else nf1 = freq_r;
    if (hyst && nf1 < hs_freq_r) nf1 = hs_freq_r;
  end
  assign hold1 = !jmax && cur_r >= hs_freq_r && nf1 > cur_r && el_hs < TW'(dly);
  assign hold2 = !jmax_r && nf2_r < floor_f_r && el_fl < TW'(min_smp_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      opp_lo_r   <= RST_OPP_LOW;
      opp_hi_r   <= RST_OPP_HIGH;
      tloads_r   <= RST_TLOADS;
      delays_r   <= RST_DELAYS;
      hs_freq_r  <= RST_HS_FREQ;
      hs_load_r  <= RST_HS_LOAD;
      min_smp_r  <= RST_MIN_SMP;
      max_hyst_r <= RST_MAX_HYST;
      cur_r      <= RST_OPP_LOW[FREQ_W-1:0];
      floor_f_r  <= '0;
      floor_st_r <= '0;
      hs_st_r    <= '0;
      mh_st_r    <= '0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_OPP_LOW:  opp_lo_r   <= cfg_data;
          REG_OPP_HIGH: opp_hi_r   <= cfg_data;
          REG_TLOADS:   tloads_r   <= cfg_data;
          REG_DELAYS:   delays_r   <= cfg_data;
          REG_HS_FREQ:  hs_freq_r  <= cfg_data[FREQ_W-1:0];
          REG_HS_LOAD:  hs_load_r  <= cfg_data[LOAD_W-1:0];
          REG_MIN_SMP:  min_smp_r  <= cfg_data[FREQ_W-1:0];
          REG_MAX_HYST: max_hyst_r <= cfg_data[FREQ_W-1:0];
          default: ;
        endcase
      end
      if (cmd.dec1 && !hold1) hs_st_r <= now_r;
      if (cmd.dec2 && !hold2) begin
        cur_r <= nf2_r;
        if (!jmax_r) begin
          floor_f_r  <= nf2_r;
          floor_st_r <= now_r;
          if (nf2_r >= maxf) mh_st_r <= now_r;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      load_r <= in_cpu_load;
      now_r  <= TW'(in_tick_now);
      adj_r  <= QUOT_W'(cur_r * in_cpu_load);
      freq_r <= cur_r;
      fmin_r <= '0;
      fmax_r <= '1;
      rnd_r  <= '0;
    end
    if (cmd.div_init) begin
      q_r       <= adj_r;
      rem_r     <= '0;
      dcnt_r    <= '0;
      divisor_r <= (tl_sel == '0) ? TL_W'(1) : tl_sel;
      rnd_r     <= rnd_r + 1'b1;
    end
    if (cmd.div_step) begin
      rem_r  <= dge ? TL_W'(dtrial - {1'b0, divisor_r}) : dtrial[TL_W-1:0];
      q_r    <= {q_r[QUOT_W-2:0], dge};
      dcnt_r <= dcnt_r + 1'b1;
    end
    if (cmd.eval) begin
      prev_r   <= freq_r;
      freq_r   <= ev_f;
      fix_up_r <= ev_up;
      if (ev_up) fmin_r <= freq_r;
      if (ev_dn) fmax_r <= {1'b0, freq_r};
    end
    if (cmd.fix) freq_r <= fx_f;
    if (cmd.dec1) begin
      jmax_r <= jmax;
      nf2_r  <= floor_opp(tab, NUM_LEVELS, {{LOAD_W{1'b0}}, nf1});
      if (hold1) res_r <= cur_r;
    end
    if (cmd.dec2) res_r <= hold2 ? cur_r : nf2_r;
  end

  always_comb begin
    stat.div_last    = dcnt_r == DCNT_W'(QUOT_W - 1);
    stat.eval_fix    = ev_fix;
    stat.eval_stop   = ev_f == freq_r;
    stat.fix_stop    = fx_brk || fx_f == prev_r;
    stat.rounds_last = rnd_r == RND_W'(ROUNDS);
    stat.hold1       = hold1;
  end

  assign out_chosen_frequency = res_r;

endmodule

/* hw/rtl/interactive_dvfs_governor.sv */
// ----------------------------------------------------------------------------
// interactive_dvfs_governor
// Interactive-style DVFS governor: one target frequency per load sample.
// ----------------------------------------------------------------------------
// Input channel (in_valid/in_ready) takes one sample word: cpu load percent
// and the current tick. Output channel (out_valid/out_ready) returns one
// word per sample: the chosen frequency in MHz.
// Configuration is to be written through cfg_we/cfg_index/cfg_data only while
// idle; the block itself does not enforce this. Indexes above 7 are ignored.
// Sequence: setup, then per search round a divider setup, the restoring
// divider at one quotient bit per cycle and an evaluation step with an
// optional fix step, at most 2*NUM_LEVELS+2 rounds, then the decision
// step DEC1 and, unless the result is held there, DEC2.
// One sample is in flight at a time; the next is taken once the previous
// decision is done, even while its result still waits on out_ready.
// A stalled receiver holds the result word and the next decision waits.
// Reset restores the register defaults and sets the target to table
// entry 0; it is synchronous and acts on a clock edge.
// ----------------------------------------------------------------------------
module interactive_dvfs_governor
  import idg_pkg::*;
#(
  parameter int NUM_LEVELS = 8,
  parameter int TIME_BITS  = 32
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cfg_we,
  input  logic [CIDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]  cfg_data,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [LOAD_W-1:0] in_cpu_load,
  input  logic [31:0]       in_tick_now,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [FREQ_W-1:0] out_chosen_frequency
);

  cmd_t  cmd;
  stat_t stat;

  idg_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  idg_datapath #(
    .NUM_LEVELS (NUM_LEVELS),
    .TIME_BITS  (TIME_BITS)
  ) u_dp (
    .clk                  (clk),
    .rst_n                (rst_n),
    .cfg_we               (cfg_we),
    .cfg_index            (cfg_index),
    .cfg_data             (cfg_data),
    .in_cpu_load          (in_cpu_load),
    .in_tick_now          (in_tick_now),
    .out_chosen_frequency (out_chosen_frequency),
    .cmd                  (cmd),
    .stat                 (stat)
  );

endmodule
